// ===== src/crank_pkg.sv =====
// crank_pkg: shared constants, types and state encoding for the dense rank block
// no dependencies
`default_nettype none
package crank_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VAL_W     = 64;
  localparam int RANK_W    = 6;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int RAM_W     = VAL_W + 1;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    store;
    logic                    close;
  } crank_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DUP,
    B_WRITE,
    B_RANK_I,
    B_RANK_IL,
    B_RANK_J,
    B_EMIT
  } crank_state_t;

endpackage
`default_nettype wire

// ===== src/crank_ram.sv =====
// crank_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module crank_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/crank_front.sv =====
// crank_front: accepts input items and tags each as stored or dropped, closing or not
// depends on crank_pkg
`default_nettype none
module crank_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [crank_pkg::VAL_W-1:0] in_value,
  input  wire logic                           in_end_of_batch,
  input  wire logic                           q_full,
  output logic                                q_push,
  output crank_pkg::crank_item_t              q_item
);
  import crank_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             room;

  assign room     = (cnt_r < CNT_W'(MAX_ITEMS));
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.value = in_value;
    q_item.store = room;
    q_item.close = in_end_of_batch;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_end_of_batch) begin
        cnt_nxt = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/crank_queue.sv =====
// crank_queue: short fifo of tagged items between front and back
// depends on crank_pkg
`default_nettype none
module crank_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire crank_pkg::crank_item_t push_item,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       not_empty,
  output crank_pkg::crank_item_t     head
);
  import crank_pkg::*;

  crank_item_t      ent_r [Q_DEPTH];
  logic [Q_PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_PW:0]    cnt_r, cnt_nxt;
  logic             do_pop;

  assign full      = (cnt_r == (Q_PW+1)'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = ent_r[rp_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == Q_PW'(Q_DEPTH - 1)) ? '0 : wp_r + Q_PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == Q_PW'(Q_DEPTH - 1)) ? '0 : rp_r + Q_PW'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + (Q_PW+1)'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - (Q_PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_PW+1)'(Q_DEPTH)) else $error("queue count out of range");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !push) |=> (cnt_r == $past(cnt_r) - (Q_PW+1)'(1)))
    else $error("queue count did not drop on pop");

endmodule
`default_nettype wire

// ===== src/crank_back.sv =====
// crank_back: stores values with first-occurrence bit, then ranks each on batch close
// depends on crank_pkg and crank_ram
`default_nettype none
module crank_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire crank_pkg::crank_item_t      q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [crank_pkg::RANK_W-1:0]     out_dense_rank,
  output logic                             out_last_result,
  output logic                             out_overflow
);
  import crank_pkg::*;

  crank_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        j_r, j_nxt;
  logic [CNT_W-1:0]        rank_r, rank_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    close_r, close_nxt;
  logic                    dup_r, dup_nxt;
  logic                    pend_r, pend_nxt;
  logic                    ov_r, ov_nxt;
  logic [RANK_W-1:0]       or_r, or_nxt;
  logic                    ol_r, ol_nxt;
  logic                    oo_r, oo_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_raddr;
  logic [RAM_W-1:0]        ram_wdata, ram_rdata;
  logic signed [VAL_W-1:0] rd_val;
  logic                    rd_first;
  logic                    scan_issue, scan_done;

  crank_ram #(.WIDTH(RAM_W), .DEPTH(MAX_ITEMS), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_val     = $signed(ram_rdata[VAL_W-1:0]);
  assign rd_first   = ram_rdata[VAL_W];
  assign ram_wdata  = {!dup_r, val_r};
  assign scan_issue = (j_r < cnt_r);
  assign scan_done  = !scan_issue && !pend_r;

  assign out_valid       = ov_r;
  assign out_dense_rank  = or_r;
  assign out_last_result = ol_r;
  assign out_overflow    = oo_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          if (q_item.store) begin
            state_nxt = (cnt_r == '0) ? B_WRITE : B_DUP;
          end else if (q_item.close) begin
            state_nxt = B_RANK_I;
          end
        end
      end
      B_DUP: begin
        if (scan_done) state_nxt = B_WRITE;
      end
      B_WRITE: begin
        state_nxt = close_r ? B_RANK_I : B_IDLE;
      end
      B_RANK_I:  state_nxt = B_RANK_IL;
      B_RANK_IL: state_nxt = B_RANK_J;
      B_RANK_J: begin
        if (scan_done) state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (!out_stall) state_nxt = ol_r ? B_IDLE : B_RANK_I;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and control
  always_comb begin
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    rank_nxt  = rank_r;
    i_nxt     = i_r;
    val_nxt   = val_r;
    ovf_nxt   = ovf_r;
    close_nxt = close_r;
    dup_nxt   = dup_r;
    pend_nxt  = 1'b0;
    ov_nxt    = ov_r;
    or_nxt    = or_r;
    ol_nxt    = ol_r;
    oo_nxt    = oo_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = j_r[IDX_W-1:0];
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          val_nxt   = q_item.value;
          close_nxt = q_item.close;
          dup_nxt   = 1'b0;
          j_nxt     = '0;
          i_nxt     = '0;
          if (!q_item.store) ovf_nxt = 1'b1;
        end
      end
      B_DUP: begin
        if (scan_issue) begin
          j_nxt    = j_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && rd_val == val_r) dup_nxt = 1'b1;
      end
      B_WRITE: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        i_nxt   = '0;
      end
      B_RANK_I: begin
        ram_raddr = i_r;
        pend_nxt  = 1'b1;
        j_nxt     = '0;
        rank_nxt  = '0;
      end
      B_RANK_IL: begin
        val_nxt = rd_val;
      end
      B_RANK_J: begin
        if (scan_issue) begin
          j_nxt    = j_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && rd_first && (rd_val < val_r)) rank_nxt = rank_r + CNT_W'(1);
        if (scan_done) begin
          ov_nxt = 1'b1;
          or_nxt = rank_r[RANK_W-1:0];
          ol_nxt = ((CNT_W'(i_r) + CNT_W'(1)) == cnt_r);
          oo_nxt = ovf_r;
        end
      end
      B_EMIT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (ol_r) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end else begin
            i_nxt = i_r + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    rank_r  <= rank_nxt;
    i_r     <= i_nxt;
    val_r   <= val_nxt;
    close_r <= close_nxt;
    dup_r   <= dup_nxt;
    or_r    <= or_nxt;
    ol_r    <= ol_nxt;
    oo_r    <= oo_nxt;
  end

  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (state_r == B_EMIT)) else $error("result shown outside emit");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ITEMS)) else $error("stored count above capacity");
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (cnt_r < CNT_W'(MAX_ITEMS))) else $error("write past capacity");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_stall) |=> !ov_r) else $error("result repeated");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_stall && ol_r) |=> (cnt_r == '0 && !ovf_r))
    else $error("batch state not cleared after last result");

endmodule
`default_nettype wire

// ===== src/coordinate_compression_rank.sv =====
// coordinate_compression_rank: top level of the dense rank coordinate compressor
// depends on crank_pkg, crank_front, crank_queue, crank_back, crank_ram
//
// usage
//   in_ channel carries one signed 64-bit value per item plus in_end_of_batch,
//   which marks the final value of a batch. out_ channel returns one item per
//   stored value, in arrival order: its dense rank (distinct smaller values),
//   a last mark on the final one and an overflow flag when the batch held more
//   than 64 values (the extra values are dropped, the closing item still closes).
//   a two-entry queue sits between input and the ranking engine, so input is
//   taken while results wait on a stalled receiver.
// operation
//   a stored value is first checked for a duplicate (skipped for the first value
//   of a batch): the single ram read port scans the stored values once.
//   on close, each result reads its own value, scans all stored values through
//   the ram read port and is then held in the emit state, so a batch of n values
//   takes n full scans. a stored closing item is checked and written before
//   ranking starts; a closing value dropped past capacity skips both steps.
// reset
//   rst_n (synchronous, active low) empties the queue and drops any batch in
//   progress. out_stall holds the current result in its register unchanged.
`default_nettype none
module coordinate_compression_rank (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [crank_pkg::VAL_W-1:0]  in_value,
  input  wire logic                                in_end_of_batch,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [crank_pkg::RANK_W-1:0]             out_dense_rank,
  output logic                                     out_last_result,
  output logic                                     out_overflow
);
  import crank_pkg::*;

  crank_item_t push_item, head_item;
  logic        q_full, q_push, q_pop, q_valid;

  crank_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_end_of_batch (in_end_of_batch),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  crank_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_item)
  );

  crank_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dense_rank  (out_dense_rank),
    .out_last_result (out_last_result),
    .out_overflow    (out_overflow)
  );

endmodule
`default_nettype wire

// ===== tb/coordinate_compression_rank_test.sv =====
// coordinate_compression_rank_test: self-checking bench for the dense rank compressor
// sends batches of signed values, predicts each rank in the bench and checks every result
// depends on crank_pkg and coordinate_compression_rank
`default_nettype none
module coordinate_compression_rank_test;
  import crank_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [7:0] STALL_PATTERN = 8'b0011_0110;

  typedef struct packed {
    logic [RANK_W-1:0] dense_rank;
    logic              last_result;
    logic              overflow;
  } rank_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_value;
  logic                    in_end_of_batch;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [RANK_W-1:0]       out_dense_rank;
  logic                    out_last_result;
  logic                    out_overflow;

  // bench copy of the batch store
  logic signed [VAL_W-1:0] held_values [MAX_ITEMS];
  logic                    held_first  [MAX_ITEMS];
  int                      held_count    = 0;
  logic                    held_overflow = 1'b0;
  rank_result_t            expected_ranks [$];
  rank_result_t            want_rank;

  int   error_count    = 0;
  int   items_sent     = 0;
  int   batches_closed = 0;
  int   ranks_checked  = 0;
  int   idle_cycles    = 0;
  int   burst_left     = 0;
  logic sender_idles   = 1'b0;
  int   stall_style    = 0;
  int   style_left     = 0;
  logic [7:0] cycle_count = '0;

  coordinate_compression_rank dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_end_of_batch (in_end_of_batch),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dense_rank  (out_dense_rank),
    .out_last_result (out_last_result),
    .out_overflow    (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void predict_ranks(input logic signed [VAL_W-1:0] v, input logic eob);
    logic         is_first;
    int           rank;
    rank_result_t res;
    if (held_count < MAX_ITEMS) begin
      is_first = 1'b1;
      for (int j = 0; j < held_count; j++) begin
        if (held_values[j] == v) is_first = 1'b0;
      end
      held_values[held_count] = v;
      held_first[held_count]  = is_first;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (eob) begin
      for (int i = 0; i < held_count; i++) begin
        rank = 0;
        for (int j = 0; j < held_count; j++) begin
          if (held_first[j] && held_values[j] < held_values[i]) rank++;
        end
        res.dense_rank  = rank[RANK_W-1:0];
        res.last_result = (i == held_count - 1);
        res.overflow    = held_overflow;
        expected_ranks.insert(expected_ranks.size(), res);
      end
      held_count    = 0;
      held_overflow = 1'b0;
      batches_closed++;
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = 64'($urandom_range(0, 9));
        v = v - 64'sd5;
      end
      4: v = VAL_MIN + 64'($urandom_range(0, 3));
      5: v = VAL_MAX - 64'($urandom_range(0, 3));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic send_item(input logic signed [VAL_W-1:0] v, input logic eob);
    int gap;
    in_valid        <= 1'b1;
    in_value        <= v;
    in_end_of_batch <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_ranks(v, eob);
    items_sent++;
    if (sender_idles) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 6);
        gap        = $urandom_range(1, 8);
        in_valid  <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_all_ranked();
    in_valid <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_values();
    sender_idles = 1'b0;
    send_item(VAL_MAX, 1'b1);
    send_item(VAL_MIN, 1'b1);
    send_item(64'sd0, 1'b1);
    send_item(-64'sd1, 1'b1);
    wait_all_ranked();
  endtask

  task automatic test_extremes();
    sender_idles = 1'b1;
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(64'sd0, 1'b0);
    send_item(-64'sd1, 1'b0);
    send_item(64'sd1, 1'b0);
    send_item(VAL_MIN + 64'sd1, 1'b0);
    send_item(VAL_MAX - 64'sd1, 1'b0);
    send_item(64'h5555_5555_5555_5555, 1'b0);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    wait_all_ranked();
  endtask

  task automatic test_duplicates();
    sender_idles = 1'b1;
    send_item(64'sd5, 1'b0);
    send_item(64'sd5, 1'b0);
    send_item(-64'sd3, 1'b0);
    send_item(64'sd5, 1'b0);
    send_item(-64'sd3, 1'b0);
    send_item(64'sd7, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(VAL_MIN, 1'b1);
    wait_all_ranked();
  endtask

  // fills the store with mostly distinct values, then the closing item arrives past capacity
  task automatic test_overflow();
    sender_idles = 1'b1;
    for (int k = 0; k < MAX_ITEMS + 2; k++) begin
      if (k < MAX_ITEMS && (k % 4) != 0) begin
        send_item({$urandom, $urandom}, 1'b0);
      end else begin
        send_item(pick_value(), k == MAX_ITEMS + 1);
      end
    end
    wait_all_ranked();
  endtask

  task automatic test_random_batches();
    int len;
    int sent_here;
    sent_here = 0;
    while (sent_here < 40) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      sender_idles = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len; k++) begin
        send_item(pick_value(), k == len - 1);
      end
      sent_here += len;
    end
    wait_all_ranked();
  endtask

  // receiver stall, switching between none, random and a fixed pattern
  always @(posedge clk) begin
    cycle_count <= cycle_count + 8'd1;
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 2);
      style_left  <= $urandom_range(20, 300);
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= STALL_PATTERN[cycle_count[2:0]];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ranks.size() == 0) begin
        $error("unexpected result: dense_rank %0d last_result %0d overflow %0d",
               out_dense_rank, out_last_result, out_overflow);
        error_count++;
      end else begin
        want_rank = expected_ranks.pop_front();
        ranks_checked++;
        if (out_dense_rank !== want_rank.dense_rank) begin
          $error("dense_rank: expected %0d, actual %0d", want_rank.dense_rank, out_dense_rank);
          error_count++;
        end
        if (out_last_result !== want_rank.last_result) begin
          $error("last_result: expected %0d, actual %0d",
                 want_rank.last_result, out_last_result);
          error_count++;
        end
        if (out_overflow !== want_rank.overflow) begin
          $error("overflow: expected %0d, actual %0d", want_rank.overflow, out_overflow);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles with no item moving", idle_cycles);
      $display("** coordinate_compression_rank: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_value        <= '0;
    in_end_of_batch <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_values();
    test_extremes();
    test_duplicates();
    test_overflow();
    test_random_batches();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_ranks.size() != 0) begin
      $error("%0d expected results never arrived", expected_ranks.size());
      error_count++;
    end
    $display("sent %0d values in %0d batches, one of them filled and run past capacity",
             items_sent, batches_closed);
    $display("checked %0d ranks with random sender gaps and receiver stalls", ranks_checked);
    if (error_count == 0) begin
      $display("** coordinate_compression_rank: PASSED **");
    end else begin
      $display("** coordinate_compression_rank: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
